// ----- sv/ubx_frame_receiver_assert.svh -----
// Assertion macros for the UBX frame receiver.
// Expects clk and rst_n in scope at the point of use.
`ifndef UBX_FRAME_RECEIVER_ASSERT_SVH
`define UBX_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define UBX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ubx_frame_receiver: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define UBX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ubx_frame_receiver: next-cycle check failed");

`endif

// ----- sv/ubx_pkg.sv -----
// Types and constants for the UBX frame receiver.
// No dependencies.
package ubx_pkg;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_t;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_HEADER  = 2'd0;
  localparam kind_t KIND_PAYLOAD = 2'd1;
  localparam kind_t KIND_TRAILER = 2'd2;

  localparam logic [7:0]  SYNC_FIRST        = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND       = 8'h62;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd100;

endpackage

// ----- sv/ubx_frame_receiver.sv -----
// UBX frame receiver: byte-wise sync hunt, header decode and payload split.
// Depends on ubx_pkg and ubx_frame_receiver_assert.svh.
//
// Usage:
//   in_*   : one received serial byte per word (in_rx_byte).
//   out_*  : header, payload byte or checksum trailer words; out_kind tells
//            which. Fields not used by a kind read as zero.
//   cfg_*  : cfg_wr_en writes cfg_wr_data into max_payload (reset 100).
//            The limit is sampled when the high length byte arrives.
// Output: a byte that yields a result shows it on out_valid in the cycle after
// it is accepted. Bytes for sync, class, id, low length and the first
// checksum byte yield no result, nor does a high length byte over the limit.
// Throughput: one byte per cycle while in_stall is low, set by the single
// output register; the phase machine itself never waits.
// Stall: in_stall rises only while a result sits in the output register and
// out_stall is high; the held word stays put until taken.
// Reset: synchronous, active low; returns to the sync hunt with an empty
// output register and the limit back at 100.
module ubx_frame_receiver
  import ubx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_msg_class,
  output logic [7:0]  out_msg_id,
  output logic [15:0] out_payload_len,
  output logic [15:0] out_payload_index,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_check_a,
  output logic [7:0]  out_check_b,
  output logic        out_frame_end
);

`include "ubx_frame_receiver_assert.svh"

  phase_t      phase_r, phase_nxt;
  logic [7:0]  class_hold_r, class_hold_nxt;
  logic [7:0]  id_hold_r, id_hold_nxt;
  logic [15:0] length_hold_r, length_hold_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [7:0]  first_check_hold_r, first_check_hold_nxt;
  logic [15:0] max_payload_r;

  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r, out_kind_nxt;
  logic [7:0]  out_class_r, out_class_nxt;
  logic [7:0]  out_id_r, out_id_nxt;
  logic [15:0] out_len_r, out_len_nxt;
  logic [15:0] out_index_r, out_index_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic [7:0]  out_ck_a_r, out_ck_a_nxt;
  logic [7:0]  out_ck_b_r, out_ck_b_nxt;
  logic        out_end_r, out_end_nxt;

  logic        accept;
  logic [15:0] len_full;
  logic [16:0] count_inc;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign len_full  = {in_rx_byte, length_hold_r[7:0]};
  assign count_inc = {1'b0, byte_count_r} + 17'd1;

  always_comb begin
    phase_nxt            = phase_r;
    class_hold_nxt       = class_hold_r;
    id_hold_nxt          = id_hold_r;
    length_hold_nxt      = length_hold_r;
    byte_count_nxt       = byte_count_r;
    first_check_hold_nxt = first_check_hold_r;

    // drop the held word once taken
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_class_nxt = out_class_r;
    out_id_nxt    = out_id_r;
    out_len_nxt   = out_len_r;
    out_index_nxt = out_index_r;
    out_data_nxt  = out_data_r;
    out_ck_a_nxt  = out_ck_a_r;
    out_ck_b_nxt  = out_ck_b_r;
    out_end_nxt   = out_end_r;

    if (accept) begin
      case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == SYNC_FIRST) phase_nxt = PH_SYNC2;
        end
        PH_SYNC2: begin
          // a bad second sync byte is consumed, not rechecked
          phase_nxt = (in_rx_byte == SYNC_SECOND) ? PH_CLASS : PH_HUNT;
        end
        PH_CLASS: begin
          class_hold_nxt = in_rx_byte;
          phase_nxt      = PH_ID;
        end
        PH_ID: begin
          id_hold_nxt = in_rx_byte;
          phase_nxt   = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length_hold_nxt = {8'd0, in_rx_byte};
          phase_nxt       = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          length_hold_nxt = len_full;
          if (len_full > max_payload_r) begin
            phase_nxt = PH_HUNT;
          end else begin
            byte_count_nxt = 16'd0;
            phase_nxt      = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = KIND_HEADER;
            out_class_nxt  = class_hold_r;
            out_id_nxt     = id_hold_r;
            out_len_nxt    = len_full;
            out_index_nxt  = 16'd0;
            out_data_nxt   = 8'd0;
            out_ck_a_nxt   = 8'd0;
            out_ck_b_nxt   = 8'd0;
            out_end_nxt    = 1'b0;
          end
        end
        PH_PAYLOAD: begin
          byte_count_nxt = count_inc[15:0];
          if (count_inc >= {1'b0, length_hold_r}) phase_nxt = PH_CK_A;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_PAYLOAD;
          out_class_nxt = class_hold_r;
          out_id_nxt    = id_hold_r;
          out_len_nxt   = length_hold_r;
          out_index_nxt = byte_count_r;
          out_data_nxt  = in_rx_byte;
          out_ck_a_nxt  = 8'd0;
          out_ck_b_nxt  = 8'd0;
          out_end_nxt   = 1'b0;
        end
        PH_CK_A: begin
          first_check_hold_nxt = in_rx_byte;
          phase_nxt            = PH_CK_B;
        end
        PH_CK_B: begin
          phase_nxt     = PH_HUNT;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_TRAILER;
          out_class_nxt = class_hold_r;
          out_id_nxt    = id_hold_r;
          out_len_nxt   = length_hold_r;
          out_index_nxt = 16'd0;
          out_data_nxt  = 8'd0;
          out_ck_a_nxt  = first_check_hold_r;
          out_ck_b_nxt  = in_rx_byte;
          out_end_nxt   = 1'b1;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r            <= PH_HUNT;
      class_hold_r       <= 8'd0;
      id_hold_r          <= 8'd0;
      length_hold_r      <= 16'd0;
      byte_count_r       <= 16'd0;
      first_check_hold_r <= 8'd0;
      max_payload_r      <= MAX_PAYLOAD_RESET;
      out_valid_r        <= 1'b0;
    end else begin
      phase_r            <= phase_nxt;
      class_hold_r       <= class_hold_nxt;
      id_hold_r          <= id_hold_nxt;
      length_hold_r      <= length_hold_nxt;
      byte_count_r       <= byte_count_nxt;
      first_check_hold_r <= first_check_hold_nxt;
      out_valid_r        <= out_valid_nxt;
      if (cfg_wr_en) max_payload_r <= cfg_wr_data;
    end
  end

  // result word: payload only, no reset
  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_class_r <= out_class_nxt;
    out_id_r    <= out_id_nxt;
    out_len_r   <= out_len_nxt;
    out_index_r <= out_index_nxt;
    out_data_r  <= out_data_nxt;
    out_ck_a_r  <= out_ck_a_nxt;
    out_ck_b_r  <= out_ck_b_nxt;
    out_end_r   <= out_end_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_msg_class     = out_class_r;
  assign out_msg_id        = out_id_r;
  assign out_payload_len   = out_len_r;
  assign out_payload_index = out_index_r;
  assign out_data_byte     = out_data_r;
  assign out_check_a       = out_ck_a_r;
  assign out_check_b       = out_ck_b_r;
  assign out_frame_end     = out_end_r;

  `UBX_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid_r)
  `UBX_ASSERT_NOW(a_trailer_ends_frame, out_valid_r && (out_kind_r == KIND_TRAILER), out_end_r)
  `UBX_ASSERT_NOW(a_count_below_len, phase_r == PH_PAYLOAD, byte_count_r < length_hold_r)
  `UBX_ASSERT_NEXT(a_payload_emits, accept && (phase_r == PH_PAYLOAD), out_valid_r && (out_kind_r == KIND_PAYLOAD))

endmodule

// ----- verif/tb_ubx_frame_receiver.sv -----
// Testbench for ubx_frame_receiver: byte stream in, header/payload/trailer words out.
// Uses ubx_pkg for phases, kinds and sync constants; predicts every output word itself.
module tb_ubx_frame_receiver;
  import ubx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_len;
    logic [15:0] payload_index;
    logic [7:0]  data_byte;
    logic [7:0]  check_a;
    logic [7:0]  check_b;
    logic        frame_end;
  } ubx_word_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte  = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_msg_class;
  logic [7:0]  out_msg_id;
  logic [15:0] out_payload_len;
  logic [15:0] out_payload_index;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_check_a;
  logic [7:0]  out_check_b;
  logic        out_frame_end;

  // Predictor state, reset values of the block.
  phase_t      rx_phase       = PH_HUNT;
  logic [7:0]  class_seen     = '0;
  logic [7:0]  id_seen        = '0;
  logic [15:0] length_seen    = '0;
  logic [15:0] payload_count  = '0;
  logic [7:0]  check_a_seen   = '0;
  logic [15:0] payload_limit  = MAX_PAYLOAD_RESET;

  logic [7:0]  pending_bytes[$];
  ubx_word_t   expected_words[$];
  bit          byte_taken = 1'b0;
  int          idle_pct   = 0;
  int          stall_pct  = 0;
  int          error_count = 0;

  ubx_frame_receiver DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_msg_class     (out_msg_class),
    .out_msg_id        (out_msg_id),
    .out_payload_len   (out_payload_len),
    .out_payload_index (out_payload_index),
    .out_data_byte     (out_data_byte),
    .out_check_a       (out_check_a),
    .out_check_b       (out_check_b),
    .out_frame_end     (out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void predict_frame_word(input logic [7:0] b, output bit has_word,
                                             output ubx_word_t w);
    has_word = 1'b0;
    w = '0;
    w.msg_class = class_seen;
    w.msg_id = id_seen;
    case (rx_phase)
      PH_HUNT: begin
        if (b == SYNC_FIRST) rx_phase = PH_SYNC2;
      end
      // A bad second sync byte is eaten, not retried as a first sync byte.
      PH_SYNC2: begin
        rx_phase = (b == SYNC_SECOND) ? PH_CLASS : PH_HUNT;
      end
      PH_CLASS: begin
        class_seen = b;
        rx_phase = PH_ID;
      end
      PH_ID: begin
        id_seen = b;
        rx_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_seen = {8'h00, b};
        rx_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_seen = {b, length_seen[7:0]};
        if (length_seen > payload_limit) begin
          rx_phase = PH_HUNT;
        end else begin
          payload_count = '0;
          rx_phase = (length_seen == 16'd0) ? PH_CK_A : PH_PAYLOAD;
          has_word = 1'b1;
          w.kind = KIND_HEADER;
          w.msg_class = class_seen;
          w.msg_id = id_seen;
          w.payload_len = length_seen;
        end
      end
      PH_PAYLOAD: begin
        has_word = 1'b1;
        w.kind = KIND_PAYLOAD;
        w.payload_len = length_seen;
        w.payload_index = payload_count;
        w.data_byte = b;
        payload_count = payload_count + 16'd1;
        if (payload_count >= length_seen) rx_phase = PH_CK_A;
      end
      PH_CK_A: begin
        check_a_seen = b;
        rx_phase = PH_CK_B;
      end
      PH_CK_B: begin
        has_word = 1'b1;
        w.kind = KIND_TRAILER;
        w.payload_len = length_seen;
        w.check_a = check_a_seen;
        w.check_b = b;
        w.frame_end = 1'b1;
        rx_phase = PH_HUNT;
      end
      default: rx_phase = PH_HUNT;
    endcase
  endfunction

  function automatic void check_frame_word(input ubx_word_t e);
    if (out_kind !== e.kind) begin
      $error("kind expected %0d got %0d", e.kind, out_kind);
      error_count++;
    end
    if (out_msg_class !== e.msg_class) begin
      $error("msg_class expected %0h got %0h", e.msg_class, out_msg_class);
      error_count++;
    end
    if (out_msg_id !== e.msg_id) begin
      $error("msg_id expected %0h got %0h", e.msg_id, out_msg_id);
      error_count++;
    end
    if (out_payload_len !== e.payload_len) begin
      $error("payload_len expected %0d got %0d", e.payload_len, out_payload_len);
      error_count++;
    end
    if (out_payload_index !== e.payload_index) begin
      $error("payload_index expected %0d got %0d", e.payload_index, out_payload_index);
      error_count++;
    end
    if (out_data_byte !== e.data_byte) begin
      $error("data_byte expected %0h got %0h", e.data_byte, out_data_byte);
      error_count++;
    end
    if (out_check_a !== e.check_a) begin
      $error("check_a expected %0h got %0h", e.check_a, out_check_a);
      error_count++;
    end
    if (out_check_b !== e.check_b) begin
      $error("check_b expected %0h got %0h", e.check_b, out_check_b);
      error_count++;
    end
    if (out_frame_end !== e.frame_end) begin
      $error("frame_end expected %0b got %0b", e.frame_end, out_frame_end);
      error_count++;
    end
  endfunction

  // Monitor: take result words and accepted bytes at the rising edge.
  always @(posedge clk) begin
    ubx_word_t w;
    bit        has_word;
    byte_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output word, kind %0d", out_kind);
          error_count++;
        end else begin
          check_frame_word(expected_words.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        byte_taken = 1'b1;
        predict_frame_word(in_rx_byte, has_word, w);
        if (has_word) expected_words.push_back(w);
      end
    end
  end

  // Driver: change inputs at the falling edge only.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (!in_valid || byte_taken) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_rx_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void queue_frame(input logic [7:0] cls, input logic [7:0] id,
                                      input logic [15:0] len, input logic [7:0] ck_a,
                                      input logic [7:0] ck_b);
    pending_bytes.push_back(SYNC_FIRST);
    pending_bytes.push_back(SYNC_SECOND);
    pending_bytes.push_back(cls);
    pending_bytes.push_back(id);
    pending_bytes.push_back(len[7:0]);
    pending_bytes.push_back(len[15:8]);
    // Oversized frames end at the length; the next byte is a hunt byte.
    if (len <= payload_limit) begin
      for (int i = 0; i < len; i++) pending_bytes.push_back(8'($urandom));
      pending_bytes.push_back(ck_a);
      pending_bytes.push_back(ck_b);
    end
  endfunction

  function automatic void queue_random_traffic(input int target);
    int          pick;
    int          cap;
    logic [15:0] len;
    logic [7:0]  b;
    while (pending_bytes.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        cap = (payload_limit < 12) ? payload_limit : 12;
        len = 16'($urandom_range(cap, 0));
        if (pick < 7 && payload_limit <= 64) len = payload_limit;
        if (pick >= 60 && payload_limit < 16'hFFFF)
          len = 16'($urandom_range(16'hFFFF, payload_limit + 1));
        queue_frame(8'($urandom), 8'($urandom), len, 8'($urandom), 8'($urandom));
      end else if (pick < 82) begin
        b = 8'($urandom);
        if (b == SYNC_SECOND) b = ~b;
        pending_bytes.push_back(SYNC_FIRST);
        pending_bytes.push_back(b);
      end else if (pick < 86) begin
        pending_bytes.push_back(SYNC_FIRST);
        pending_bytes.push_back(SYNC_FIRST);
        pending_bytes.push_back(SYNC_SECOND);
      end else begin
        pending_bytes.push_back(8'($urandom));
      end
    end
  endfunction

  // Hold off until every byte is taken and every expected word has come.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    payload_limit = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 16'($urandom);
  endtask

  initial begin
    logic [15:0] limits[8];
    limits = '{16'd0, 16'hFFFF, 16'd1, 16'd12, 16'd255, 16'd0, 16'd100, 16'd40};
    limits[5] = 16'($urandom_range(60, 2));
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: noise, bad second sync, empty frame, short frame, oversized drop, full-size frame.
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(SYNC_FIRST);
    pending_bytes.push_back(SYNC_FIRST);
    pending_bytes.push_back(SYNC_SECOND);
    queue_frame(8'hFF, 8'h00, 16'd0, 8'h00, 8'hFF);
    queue_frame(8'h00, 8'hFF, 16'd2, 8'hFF, 8'h00);
    queue_frame(8'h01, 8'h07, MAX_PAYLOAD_RESET + 16'd1, 8'h00, 8'h00);
    queue_frame(8'h0A, 8'h05, MAX_PAYLOAD_RESET, 8'h5A, 8'hA5);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      @(posedge clk);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      write_limit(limits[ph]);
      // Send a frame with a nonzero high length byte once the limit lets it through.
      if (payload_limit == 16'hFFFF)
        queue_frame(8'($urandom), 8'($urandom), 16'd300, 8'($urandom), 8'($urandom));
      queue_random_traffic(40);
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d expected words never arrived", expected_words.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
